// File: hdl/plc_pkg.sv
// Package: sizes, codes and cell control type for the positional list store.
package plc_pkg;

  localparam int CAPACITY  = 64;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [IDX_W-1:0] pos;
    elem_t            wr_data;
  } plc_ctrl_t;

endpackage

// File: hdl/plc_cell.sv
// One storage cell of the list: holds an entry, shifts with its neighbors.
module plc_cell (
  input  logic                    clk,
  input  logic [plc_pkg::IDX_W-1:0] cell_idx,
  input  plc_pkg::plc_ctrl_t      ctrl,
  input  plc_pkg::elem_t          left_data,
  input  plc_pkg::elem_t          right_data,
  output plc_pkg::elem_t          data_o,
  output plc_pkg::elem_t          hit_data
);
  import plc_pkg::*;

  elem_t data_r;
  elem_t data_nxt;
  logic  at_pos;
  logic  above_pos;

  assign at_pos    = (cell_idx == ctrl.pos);
  assign above_pos = (cell_idx > ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_en && at_pos) begin
      data_nxt = ctrl.wr_data;
    end else if (ctrl.ins_en && above_pos) begin
      data_nxt = left_data;
    end else if (ctrl.rem_en && (at_pos || above_pos)) begin
      data_nxt = right_data;
    end
  end

  // entry payload, no reset: unwritten cells are never read
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o   = data_r;
  assign hit_data = at_pos ? data_r : '0;

endmodule

// File: hdl/positional_list_store_core.sv
// Top level: positional list store built from a row of shifting cells.
// A result appears in the output register in the cycle after acceptance.
// Throughput: one transaction per cycle; cells at and above pos shift together.
// The output register is refilled while its result is taken, so input stalls only
// when the held result is stalled.
// Reset: synchronous active-low; clears the entry count and output valid.
module positional_list_store_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [6:0]                in_position,
  input  logic [31:0]               in_item_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_data,
  output logic [1:0]                out_status,
  output logic [6:0]                out_item_count
);
  import plc_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // list state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [6:0]  out_count_r, out_count_nxt;

  logic      accept;
  logic      pos_le_cnt;   // legal insert position
  logic      pos_lt_cnt;   // legal remove or peek position
  logic      full;
  plc_ctrl_t ctrl;
  elem_t     rd_data;

  elem_t cell_data [CAPACITY];
  elem_t cell_hit  [CAPACITY];

  // a new transaction is taken unless the held result is blocked
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_le_cnt = ({1'b0, in_position} <= {1'b0, cnt_r});
  assign pos_lt_cnt = ({1'b0, in_position} <  {1'b0, cnt_r});
  assign full       = (cnt_r == CAP_CNT);

  always_comb begin
    ctrl         = '0;
    ctrl.pos     = in_position[IDX_W-1:0];
    ctrl.wr_data = in_item_data[ELEM_BITS-1:0];
    ctrl.ins_en  = accept && (in_action == ACT_INSERT) && pos_le_cnt && !full;
    ctrl.rem_en  = accept && (in_action == ACT_REMOVE) && pos_lt_cnt;
  end

  // the cell row: left neighbor feeds inserts, right neighbor feeds removes
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_in;
    elem_t right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end
    plc_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_in),
      .right_data (right_in),
      .data_o     (cell_data[i]),
      .hit_data   (cell_hit[i])
    );
  end

  // only the addressed cell drives a nonzero hit, so an OR collects it
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_hit[k];
    end
  end

  // count update and result formation
  always_comb begin
    cnt_nxt        = cnt_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = ST_RANGE;
      case (in_action)
        ACT_INSERT: begin
          if (!pos_le_cnt) begin
            out_status_nxt = ST_RANGE;
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_OK;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (pos_lt_cnt) begin
            out_status_nxt = ST_OK;
            out_data_nxt   = 32'(rd_data);
            cnt_nxt        = cnt_r - CNT_W'(1);
          end
        end
        ACT_PEEK: begin
          if (pos_lt_cnt) begin
            out_status_nxt = ST_OK;
            out_data_nxt   = 32'(rd_data);
          end
        end
        default: begin
          out_status_nxt = ST_RANGE;
        end
      endcase
      out_count_nxt = 7'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_status     = out_status_r;
  assign out_item_count = out_count_r;

  // count stays within capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  // every accepted transaction leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // a full refusal reports a full list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == 7'(CAP_CNT)))
    else $error("full status with list not full");

  // a good remove drops the count by one
  a_remove: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem_en |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("remove did not decrement count");

  // a good insert raises the count by one
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not increment count");

endmodule
